// ----- src/cvs_pkg.sv -----
// Shared types, constants and the LFSR helper function of the cache victim selector.
package cvs_pkg;

	localparam int SLOTS_DEF      = 16;
	localparam int STAMP_BITS_DEF = 32;

	localparam int SLOT_FW  = 4;
	localparam int STAMP_FW = 32;
	localparam int SIZE_W   = 24;
	localparam int SUM_W    = 32;

	localparam int               LFSR_W    = 16;
	localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
	localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

	localparam int APB_DW = 32;
	localparam int APB_AW = 3;

	localparam logic REG_POLICY = 1'b0;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EVICT = 1'b1;

	typedef enum logic [1:0] {
		POL_RANDOM  = 2'd0,
		POL_LRU     = 2'd1,
		POL_LARGEST = 2'd2,
		POL_NONE    = 2'd3
	} policy_t;

	localparam policy_t POLICY_RESET = POL_LRU;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WR_RD,
		ST_WR_UP,
		ST_EV_CHK,
		ST_MOD,
		ST_PICK,
		ST_SCAN,
		ST_V_RD,
		ST_EVICT,
		ST_DONE
	} state_t;

	function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
		logic [LFSR_W-1:0] s;
		s = v >> 1;
		if (v[0]) begin
			s = s ^ LFSR_TAPS;
		end
		return s;
	endfunction

endpackage

// ----- src/cvs_entry_ram.sv -----
// Single-port entry memory with registered read data.
module cvs_entry_ram #(
	parameter int DEPTH = cvs_pkg::SLOTS_DEF,
	parameter int WIDTH = cvs_pkg::STAMP_BITS_DEF + cvs_pkg::SIZE_W
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ----- src/cvs_mod_unit.sv -----
// Restoring remainder unit that yields one quotient bit per cycle.
module cvs_mod_unit #(
	parameter int DIVIDEND_W = cvs_pkg::LFSR_W,
	parameter int DIVISOR_W  = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVISOR_W-1:0]  remainder
);

	localparam int STEP_W = $clog2(DIVIDEND_W + 1);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVIDEND_W - 1);

	logic                  busy_q;
	logic                  done_q;
	logic [STEP_W-1:0]     step_q;
	logic [DIVIDEND_W-1:0] num_q;
	logic [DIVISOR_W-1:0]  den_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;
	logic [DIVISOR_W-1:0]  rem_next;

	always_comb begin
		trial = {rem_q, num_q[DIVIDEND_W-1]};
		diff  = trial - {1'b0, den_q};
		if (trial >= {1'b0, den_q}) begin
			rem_next = diff[DIVISOR_W-1:0];
		end else begin
			rem_next = trial[DIVISOR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= rem_next;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// ----- src/cvs_ctrl.sv -----
// Sequencer that reads, modifies and writes back the entry memory, selects the victim and keeps the totals.
module cvs_ctrl #(
	parameter int SLOTS      = cvs_pkg::SLOTS_DEF,
	parameter int STAMP_BITS = cvs_pkg::STAMP_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cvs_pkg::policy_t             policy,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         operation,
	input  logic [cvs_pkg::SLOT_FW-1:0]  slot,
	input  logic [cvs_pkg::STAMP_FW-1:0] entry_stamp,
	input  logic [cvs_pkg::SIZE_W-1:0]   entry_size,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         evicted,
	output logic [cvs_pkg::SLOT_FW-1:0]  victim_slot,
	output logic [cvs_pkg::SIZE_W-1:0]   victim_size,
	output logic [cvs_pkg::SUM_W-1:0]    total_size
);

	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int CNT_W   = $clog2(SLOTS + 1);
	localparam int SIZE_W  = cvs_pkg::SIZE_W;
	localparam int SUM_W   = cvs_pkg::SUM_W;
	localparam int ENTRY_W = STAMP_BITS + SIZE_W;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

	cvs_pkg::state_t state_q, state_d;

	logic [SLOTS-1:0]              valid_q;
	logic [CNT_W-1:0]              count_q;
	logic [SUM_W-1:0]              sum_q;
	logic [cvs_pkg::LFSR_W-1:0]    lfsr_q;
	logic [cvs_pkg::LFSR_W-1:0]    lfsr_adv;

	logic [SLOT_W-1:0]             slot_q;
	logic [STAMP_BITS-1:0]         stamp_q;
	logic [SIZE_W-1:0]             size_q;

	logic [SLOT_W-1:0]             scan_idx_q;
	logic                          issue_done_q;
	logic                          rd_vld_s1;
	logic [SLOT_W-1:0]             rd_idx_s1;
	logic                          best_found_q;
	logic [SLOT_W-1:0]             best_idx_q;
	logic [STAMP_BITS-1:0]         best_stamp_q;
	logic [SIZE_W-1:0]             best_size_q;
	logic [SLOT_W-1:0]             victim_q;
	logic [CNT_W-1:0]              seen_q;

	logic                          res_evicted_q;
	logic [SLOT_W-1:0]             res_slot_q;
	logic [SIZE_W-1:0]             res_size_q;

	logic                          out_valid_q;
	logic                          out_evicted_q;
	logic [cvs_pkg::SLOT_FW-1:0]   out_slot_q;
	logic [SIZE_W-1:0]             out_size_q;
	logic [SUM_W-1:0]              out_total_q;

	logic                          ram_we;
	logic [SLOT_W-1:0]             ram_addr;
	logic [ENTRY_W-1:0]            ram_rdata;
	logic [STAMP_BITS-1:0]         rd_stamp;
	logic [SIZE_W-1:0]             rd_size;

	logic                          mod_start;
	logic                          mod_done;
	logic [CNT_W-1:0]              mod_rem;

	logic [SLOT_W+3:0]             slot_ext;
	logic                          slot_ok;
	logic [STAMP_BITS+31:0]        stamp_ext;
	logic [SLOT_W+3:0]             vslot_ext;
	logic                          accept;
	logic                          load_out;
	logic                          better;
	logic [SIZE_W-1:0]             old_size;

	assign slot_ext  = {SLOT_W'(0), slot};
	assign slot_ok   = slot_ext < (SLOT_W + 4)'(SLOTS);
	assign stamp_ext = {STAMP_BITS'(0), entry_stamp};
	assign vslot_ext = {4'b0000, res_slot_q};
	assign rd_stamp  = ram_rdata[ENTRY_W-1:SIZE_W];
	assign rd_size   = ram_rdata[SIZE_W-1:0];
	assign lfsr_adv  = cvs_pkg::lfsr_next(lfsr_q);
	assign accept    = in_valid && in_ready;
	assign load_out  = (state_q == cvs_pkg::ST_DONE) && (!out_valid_q || out_ready);
	assign old_size  = valid_q[slot_q] ? rd_size : '0;

	always_comb begin
		better = !best_found_q;
		if (best_found_q) begin
			if (policy == cvs_pkg::POL_LRU) begin
				better = rd_stamp < best_stamp_q;
			end else begin
				better = rd_size > best_size_q;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			cvs_pkg::ST_IDLE: begin
				if (accept) begin
					if (operation == cvs_pkg::OP_EVICT) begin
						state_d = cvs_pkg::ST_EV_CHK;
					end else if (slot_ok) begin
						state_d = cvs_pkg::ST_WR_RD;
					end else begin
						state_d = cvs_pkg::ST_DONE;
					end
				end
			end
			cvs_pkg::ST_WR_RD: state_d = cvs_pkg::ST_WR_UP;
			cvs_pkg::ST_WR_UP: state_d = cvs_pkg::ST_DONE;
			cvs_pkg::ST_EV_CHK: begin
				if (count_q == '0 || policy == cvs_pkg::POL_NONE) begin
					state_d = cvs_pkg::ST_DONE;
				end else if (policy == cvs_pkg::POL_RANDOM) begin
					state_d = cvs_pkg::ST_MOD;
				end else begin
					state_d = cvs_pkg::ST_SCAN;
				end
			end
			cvs_pkg::ST_MOD: begin
				if (mod_done) begin
					state_d = cvs_pkg::ST_PICK;
				end
			end
			cvs_pkg::ST_PICK: begin
				if (valid_q[scan_idx_q] && seen_q == mod_rem) begin
					state_d = cvs_pkg::ST_V_RD;
				end
			end
			cvs_pkg::ST_SCAN: begin
				if (issue_done_q && !rd_vld_s1) begin
					state_d = cvs_pkg::ST_V_RD;
				end
			end
			cvs_pkg::ST_V_RD: state_d = cvs_pkg::ST_EVICT;
			cvs_pkg::ST_EVICT: state_d = cvs_pkg::ST_DONE;
			cvs_pkg::ST_DONE: begin
				if (load_out) begin
					state_d = cvs_pkg::ST_IDLE;
				end
			end
			default: state_d = cvs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = slot_q;
		mod_start = 1'b0;
		case (state_q)
			cvs_pkg::ST_IDLE: in_ready = 1'b1;
			cvs_pkg::ST_WR_UP: ram_we = 1'b1;
			cvs_pkg::ST_EV_CHK: begin
				mod_start = (count_q != '0) && (policy == cvs_pkg::POL_RANDOM);
			end
			cvs_pkg::ST_SCAN: ram_addr = scan_idx_q;
			cvs_pkg::ST_V_RD: ram_addr = victim_q;
			default: ram_addr = slot_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= cvs_pkg::ST_IDLE;
			valid_q       <= '0;
			count_q       <= '0;
			sum_q         <= '0;
			lfsr_q        <= cvs_pkg::LFSR_SEED;
			issue_done_q  <= 1'b0;
			rd_vld_s1     <= 1'b0;
			best_found_q  <= 1'b0;
			res_evicted_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				cvs_pkg::ST_IDLE: begin
					if (accept) begin
						res_evicted_q <= 1'b0;
					end
				end
				cvs_pkg::ST_WR_UP: begin
					valid_q[slot_q] <= 1'b1;
					sum_q           <= sum_q - SUM_W'(old_size) + SUM_W'(size_q);
					if (!valid_q[slot_q]) begin
						count_q <= count_q + 1'b1;
					end
				end
				cvs_pkg::ST_EV_CHK: begin
					issue_done_q <= 1'b0;
					rd_vld_s1    <= 1'b0;
					best_found_q <= 1'b0;
					if (mod_start) begin
						lfsr_q <= lfsr_adv;
					end
				end
				cvs_pkg::ST_SCAN: begin
					rd_vld_s1 <= !issue_done_q;
					if (!issue_done_q && scan_idx_q == LAST_SLOT) begin
						issue_done_q <= 1'b1;
					end
					if (rd_vld_s1 && valid_q[rd_idx_s1] && better) begin
						best_found_q <= 1'b1;
					end
				end
				cvs_pkg::ST_EVICT: begin
					valid_q[victim_q] <= 1'b0;
					count_q           <= count_q - 1'b1;
					sum_q             <= sum_q - SUM_W'(rd_size);
					res_evicted_q     <= 1'b1;
				end
				default: begin
				end
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			cvs_pkg::ST_IDLE: begin
				if (accept) begin
					slot_q     <= slot_ext[SLOT_W-1:0];
					stamp_q    <= stamp_ext[STAMP_BITS-1:0];
					size_q     <= entry_size;
					res_slot_q <= '0;
					res_size_q <= '0;
				end
			end
			cvs_pkg::ST_EV_CHK: begin
				scan_idx_q <= '0;
				seen_q     <= '0;
			end
			cvs_pkg::ST_PICK: begin
				scan_idx_q <= scan_idx_q + 1'b1;
				victim_q   <= scan_idx_q;
				if (valid_q[scan_idx_q]) begin
					seen_q <= seen_q + 1'b1;
				end
			end
			cvs_pkg::ST_SCAN: begin
				rd_idx_s1 <= scan_idx_q;
				victim_q  <= best_idx_q;
				if (!issue_done_q && scan_idx_q != LAST_SLOT) begin
					scan_idx_q <= scan_idx_q + 1'b1;
				end
				if (rd_vld_s1 && valid_q[rd_idx_s1] && better) begin
					best_idx_q   <= rd_idx_s1;
					best_stamp_q <= rd_stamp;
					best_size_q  <= rd_size;
				end
			end
			cvs_pkg::ST_EVICT: begin
				res_slot_q <= victim_q;
				res_size_q <= rd_size;
			end
			default: begin
			end
		endcase
		if (load_out) begin
			out_evicted_q <= res_evicted_q;
			out_slot_q    <= vslot_ext[3:0];
			out_size_q    <= res_size_q;
			out_total_q   <= sum_q;
		end
	end

	cvs_entry_ram #(
		.DEPTH (SLOTS),
		.WIDTH (ENTRY_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata ({stamp_q, size_q}),
		.rdata (ram_rdata)
	);

	cvs_mod_unit #(
		.DIVIDEND_W (cvs_pkg::LFSR_W),
		.DIVISOR_W  (CNT_W)
	) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (lfsr_adv),
		.divisor   (count_q),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	assign out_valid   = out_valid_q;
	assign evicted     = out_evicted_q;
	assign victim_slot = out_slot_q;
	assign victim_size = out_size_q;
	assign total_size  = out_total_q;

endmodule

// ----- src/cache_victim_selector_core.sv -----
// Top level of the cache victim selector: register port, sequencer and checks.
// One item is worked on at a time; in_ready rises in the same cycle that the result is loaded onto the output.
// A write reads the old entry and then writes the new one; an evict with no valid entry or with
// the none policy finds no victim; least recently used and largest size read the memory once per slot,
// and random takes a bit-serial remainder, then a walk of valid bits, before the victim is read.
// Reset clears valid bits, count and total, seeds the LFSR with 0xACE1 and sets policy 1.
module cache_victim_selector_core #(
	parameter int SLOTS      = cvs_pkg::SLOTS_DEF,
	parameter int STAMP_BITS = cvs_pkg::STAMP_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [cvs_pkg::APB_AW-1:0]   paddr,
	input  logic [cvs_pkg::APB_DW-1:0]   pwdata,
	output logic [cvs_pkg::APB_DW-1:0]   prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         operation,
	input  logic [cvs_pkg::SLOT_FW-1:0]  slot,
	input  logic [cvs_pkg::STAMP_FW-1:0] entry_stamp,
	input  logic [cvs_pkg::SIZE_W-1:0]   entry_size,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         evicted,
	output logic [cvs_pkg::SLOT_FW-1:0]  victim_slot,
	output logic [cvs_pkg::SIZE_W-1:0]   victim_size,
	output logic [cvs_pkg::SUM_W-1:0]    total_size
);

	cvs_pkg::policy_t policy_q;
	logic             policy_wr;
	logic             policy_sel;

	assign policy_sel = paddr[2] == cvs_pkg::REG_POLICY;
	assign policy_wr  = psel && penable && pwrite && pready && policy_sel;
	assign pready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= cvs_pkg::POLICY_RESET;
		end else if (policy_wr) begin
			policy_q <= cvs_pkg::policy_t'(pwdata[1:0]);
		end
	end

	always_comb begin
		prdata = '0;
		if (policy_sel) begin
			prdata = {{(cvs_pkg::APB_DW - 2){1'b0}}, policy_q};
		end
	end

	cvs_ctrl #(
		.SLOTS      (SLOTS),
		.STAMP_BITS (STAMP_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.policy      (policy_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.slot        (slot),
		.entry_stamp (entry_stamp),
		.entry_size  (entry_size),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.evicted     (evicted),
		.victim_slot (victim_slot),
		.victim_size (victim_size),
		.total_size  (total_size)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("A second input beat was taken while an item was in work.");

	a_no_victim_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !evicted |-> victim_slot == '0 && victim_size == '0)
		else $error("A result beat without a victim carries a slot or size.");

	a_policy_write: assert property (@(posedge clk) disable iff (!arst_n)
		policy_wr |=> policy_q == cvs_pkg::policy_t'($past(pwdata[1:0])))
		else $error("The policy register did not take the written value.");

endmodule
